// File: hw/rtl/tsg_pkg.sv
package tsg_pkg;

  // Field widths
  localparam int VW  = 16;  // vertex coordinate
  localparam int RW  = 12;  // row and span columns
  localparam int YW  = 18;  // running row, signed
  localparam int HW  = 17;  // edge deltas, signed
  localparam int DSW = 18;  // row offset from edge start, signed
  localparam int PW  = 35;  // product and quotient magnitude
  localparam int XW  = 36;  // interpolated x, signed
  localparam int DIVCW = $clog2(PW);

  typedef struct packed {
    logic signed [VW-1:0] top_x;
    logic signed [VW-1:0] top_y;
    logic signed [VW-1:0] mid_x;
    logic signed [VW-1:0] mid_y;
    logic signed [VW-1:0] far_x;
    logic signed [VW-1:0] far_y;
  } tri_in_t;

  typedef struct packed {
    logic signed [RW-1:0] row;
    logic signed [RW-1:0] span_first;
    logic signed [RW-1:0] span_final;
    logic                 span_empty;
    logic                 clipped;
    logic                 last_span;
  } span_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_LMUL,
    S_LDIV,
    S_RMUL,
    S_RDIV,
    S_FORM,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic edge_long;
    logic mul;
    logic div_step;
    logic use_fb;
    logic form;
    logic next_row;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic flat;
    logic div_last;
    logic last_row;
  } sts_t;

  // Clamp a wide column to the 12-bit output range
  function automatic logic signed [RW-1:0] sat12(input logic signed [XW-1:0] v);
    logic signed [RW-1:0] r;
    if (v > XW'(2047)) begin
      r = 12'sd2047;
    end else if (v < -XW'(2048)) begin
      r = -12'sd2048;
    end else begin
      r = v[RW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tsg_ctrl.sv
module tsg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tsg_pkg::sts_t sts,
  output tsg_pkg::cmd_t cmd
);

  tsg_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence setup, then per row the short-edge and long-edge interpolations, the span forming and the emit
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      tsg_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tsg_pkg::S_SETUP;
        end
      end
      tsg_pkg::S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.count_zero ? tsg_pkg::S_IDLE : tsg_pkg::S_LMUL;
      end
      tsg_pkg::S_LMUL: begin
        if (sts.flat) begin
          cmd.use_fb = 1'b1;
          state_nxt  = tsg_pkg::S_RMUL;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = tsg_pkg::S_LDIV;
        end
      end
      tsg_pkg::S_LDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = tsg_pkg::S_RMUL;
        end
      end
      tsg_pkg::S_RMUL: begin
        cmd.edge_long = 1'b1;
        if (sts.flat) begin
          cmd.use_fb = 1'b1;
          state_nxt  = tsg_pkg::S_FORM;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = tsg_pkg::S_RDIV;
        end
      end
      tsg_pkg::S_RDIV: begin
        cmd.edge_long = 1'b1;
        cmd.div_step  = 1'b1;
        if (sts.div_last) begin
          state_nxt = tsg_pkg::S_FORM;
        end
      end
      tsg_pkg::S_FORM: begin
        cmd.form  = 1'b1;
        state_nxt = tsg_pkg::S_EMIT;
      end
      tsg_pkg::S_EMIT: begin
        if (!out_stall) begin
          cmd.next_row = 1'b1;
          state_nxt    = sts.last_row ? tsg_pkg::S_IDLE : tsg_pkg::S_LMUL;
        end
      end
      default: begin
        state_nxt = tsg_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != tsg_pkg::S_IDLE);
  assign out_valid = (state_r == tsg_pkg::S_EMIT);

  a_load_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == tsg_pkg::S_SETUP))
    else $error("accepted triangle did not enter setup");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsg_pkg::S_LDIV && !sts.div_last) |=> (state_r == tsg_pkg::S_LDIV))
    else $error("left division left early");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsg_pkg::S_EMIT && !out_stall && sts.last_row)
      |=> (state_r == tsg_pkg::S_IDLE))
    else $error("last span did not return to idle");

endmodule

// File: hw/rtl/tsg_dpath.sv
module tsg_dpath #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tsg_pkg::tri_in_t   in_data,
  input  tsg_pkg::cmd_t      cmd,
  output tsg_pkg::sts_t      sts,
  output tsg_pkg::span_out_t out_data
);

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int FLAT = (15 * ONE) / 100;
  localparam int CW   = $clog2(MAX_ROWS + 1);
  localparam logic signed [tsg_pkg::HW-1:0] FLAT_C = tsg_pkg::HW'(FLAT);
  localparam logic signed [tsg_pkg::HW-1:0] ONE_M1 = tsg_pkg::HW'(ONE - 1);
  localparam logic signed [tsg_pkg::XW-1:0] ONE_MX = tsg_pkg::XW'(ONE - 1);
  localparam logic signed [tsg_pkg::YW-1:0] MAXR   = tsg_pkg::YW'(MAX_ROWS);

  // Sorted vertices
  logic signed [tsg_pkg::VW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [tsg_pkg::VW-1:0] sax, say, sbx, sby, scx, scy, tx, ty;

  // Row control
  logic signed [tsg_pkg::YW-1:0] y_r;
  logic signed [tsg_pkg::HW-1:0] ymid_r;
  logic [CW-1:0]                 count_r, k_r;
  logic                          clip_r;
  logic signed [tsg_pkg::HW-1:0] y0, ylast, ymid;
  logic signed [tsg_pkg::YW-1:0] total;
  logic                          none, clip;

  // Edge selection
  logic                          upper;
  logic signed [tsg_pkg::VW-1:0] px, py, qx, qy, fb;
  logic signed [tsg_pkg::HW-1:0] dy, dx;
  logic signed [25:0]            ys, dys_w;
  logic signed [tsg_pkg::DSW-1:0] dys;
  logic signed [tsg_pkg::PW-1:0] prod;
  logic [tsg_pkg::PW-1:0]        prod_mag;

  // Divider
  logic [tsg_pkg::PW-1:0]        quo_r, quo_nxt;
  logic [tsg_pkg::DSW-1:0]       rem_r, rem_nxt, shifted, dyu;
  logic                          neg_r, ge;
  logic [tsg_pkg::DIVCW-1:0]     cnt_r;
  logic signed [tsg_pkg::XW-1:0] qs, xval, xw;
  logic                          xwe;

  // Span ends
  logic signed [tsg_pkg::XW-1:0] xl_r, xr_r, lo, hi, first, final_c;
  tsg_pkg::span_out_t            out_r;

  // Sort by y with three compare-and-swap steps
  always_comb begin
    sax = in_data.top_x; say = in_data.top_y;
    sbx = in_data.mid_x; sby = in_data.mid_y;
    scx = in_data.far_x; scy = in_data.far_y;
    tx = '0; ty = '0;
    if (say > sby) begin
      tx = sax; ty = say; sax = sbx; say = sby; sbx = tx; sby = ty;
    end
    if (sby > scy) begin
      tx = sbx; ty = sby; sbx = scx; sby = scy; scx = tx; scy = ty;
    end
    if (say > sby) begin
      tx = sax; ty = say; sax = sbx; say = sby; sbx = tx; sby = ty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= sax; ay_r <= say; bx_r <= sbx;
      by_r <= sby; cx_r <= scx; cy_r <= scy;
    end
  end

  // Row range: truncated top down to floored bottom
  always_comb begin
    if (ay_r < 0) begin
      y0 = (tsg_pkg::HW'(ay_r) + ONE_M1) >>> FRAC_BITS;
    end else begin
      y0 = tsg_pkg::HW'(ay_r) >>> FRAC_BITS;
    end
    ylast = tsg_pkg::HW'(cy_r) >>> FRAC_BITS;
    ymid  = tsg_pkg::HW'(by_r) >>> FRAC_BITS;
    total = tsg_pkg::YW'(ylast) - tsg_pkg::YW'(y0) + tsg_pkg::YW'(1);
    none  = (ylast < y0);
    clip  = !none && (total > MAXR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      count_r <= '0;
    end else if (cmd.setup) begin
      k_r     <= '0;
      count_r <= none ? '0 : (clip ? CW'(MAX_ROWS) : total[CW-1:0]);
    end else if (cmd.next_row) begin
      k_r <= k_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      y_r    <= tsg_pkg::YW'(y0);
      ymid_r <= ymid;
      clip_r <= clip;
    end else if (cmd.next_row) begin
      y_r <= y_r + tsg_pkg::YW'(1);
    end
  end

  // Pick the edge and its fallback x for this row
  always_comb begin
    upper = (y_r <= tsg_pkg::YW'(ymid_r));
    if (cmd.edge_long) begin
      px = ax_r; py = ay_r; qx = cx_r; qy = cy_r;
      fb = upper ? ax_r : cx_r;
    end else if (upper) begin
      px = ax_r; py = ay_r; qx = bx_r; qy = by_r; fb = bx_r;
    end else begin
      px = bx_r; py = by_r; qx = cx_r; qy = cy_r; fb = bx_r;
    end
    dy       = tsg_pkg::HW'(qy) - tsg_pkg::HW'(py);
    dx       = tsg_pkg::HW'(qx) - tsg_pkg::HW'(px);
    ys       = 26'(y_r) <<< FRAC_BITS;
    dys_w    = ys - 26'(py);
    dys      = dys_w[tsg_pkg::DSW-1:0];
    prod     = tsg_pkg::PW'(dx) * tsg_pkg::PW'(dys);
    prod_mag = prod[tsg_pkg::PW-1] ? tsg_pkg::PW'(-prod) : tsg_pkg::PW'(prod);
  end

  // Restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r[tsg_pkg::DSW-2:0], quo_r[tsg_pkg::PW-1]};
    dyu     = {1'b0, dy};
    ge      = (shifted >= dyu);
    rem_nxt = ge ? (shifted - dyu) : shifted;
    quo_nxt = {quo_r[tsg_pkg::PW-2:0], ge};
    qs      = neg_r ? -tsg_pkg::XW'({1'b0, quo_nxt}) : tsg_pkg::XW'({1'b0, quo_nxt});
    xval    = tsg_pkg::XW'(px) + qs;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r <= prod_mag;
      rem_r <= '0;
      neg_r <= prod[tsg_pkg::PW-1];
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + tsg_pkg::DIVCW'(1);
    end
  end

  // Capture the edge x from the fallback or the finished quotient
  always_comb begin
    xwe = cmd.use_fb || (cmd.div_step && sts.div_last);
    xw  = cmd.use_fb ? tsg_pkg::XW'(fb) : xval;
  end

  always_ff @(posedge clk) begin
    if (xwe) begin
      if (cmd.edge_long) begin
        xr_r <= xw;
      end else begin
        xl_r <= xw;
      end
    end
  end

  // Order the ends and reduce to pixel columns
  always_comb begin
    lo = (xl_r > xr_r) ? xr_r : xl_r;
    hi = (xl_r > xr_r) ? xl_r : xr_r;
    if (lo < 0) begin
      first = (lo + ONE_MX) >>> FRAC_BITS;
    end else begin
      first = lo >>> FRAC_BITS;
    end
    final_c = hi >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      out_r.row        <= y_r[tsg_pkg::RW-1:0];
      out_r.span_first <= tsg_pkg::sat12(first);
      out_r.span_final <= tsg_pkg::sat12(final_c);
      out_r.span_empty <= (first > final_c);
      out_r.clipped    <= clip_r;
      out_r.last_span  <= sts.last_row;
    end
  end

  assign sts.count_zero = none;
  assign sts.flat       = (dy <= FLAT_C);
  assign sts.div_last   = (cnt_r == tsg_pkg::DIVCW'(tsg_pkg::PW - 1));
  assign sts.last_row   = ((k_r + CW'(1)) == count_r);
  assign out_data       = out_r;

endmodule

// File: hw/rtl/triangle_span_generator.sv
// Triangle span generator.
// Input channel (in_valid/in_stall/in_data): one triangle of three signed
// fixed-point vertices per transaction. The vertices are sorted by y and one
// span is produced for every pixel row from the truncated top y to the
// floored bottom y, at most MAX_ROWS rows (clipped is set when cut).
// Output channel (out_valid/out_stall/out_data): one span per transaction,
// last_span marks the final span of a triangle. A triangle with no rows
// gives no transaction.
// Operation: one triangle is worked at a time. After setup, each row is
// worked by the single shared 35-step restoring divider, which serves the
// short edge and then the long edge (each edge is started by a multiply;
// a flat edge skips the steps and takes its fallback x), then the span is
// formed and handed over. in_stall stays high until the last span has been
// taken. A stall on the output holds the span in the output register and
// freezes the row sequence. Reset returns the controller to idle and drops
// any triangle in progress; no transaction is started.
module triangle_span_generator #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsg_pkg::tri_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tsg_pkg::span_out_t out_data
);

  tsg_pkg::cmd_t cmd;
  tsg_pkg::sts_t sts;

  tsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsg_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: dv/tb_top.sv
module tb_top;

  localparam int ROW_LIMIT = 64;
  localparam int FRAC = 4;
  localparam longint UNIT = 64'sd1 << FRAC;
  localparam longint FLAT_MAX = (15 * UNIT) / 100;
  localparam int RAND_TRIS = 330;

  // Expected-span store and comparison of finished spans
  class span_scoreboard;
    tsg_pkg::span_out_t pending_spans[$];
    int mismatches;
    int spans_checked;
    int tris_noted;

    // Interpolate x on one edge at row position ys, or fall back when flat
    function longint edge_at(longint px, longint py, longint qx, longint qy,
                             longint ys, longint fb);
      longint dy;
      dy = qy - py;
      if (dy <= FLAT_MAX) return fb;
      return px + ((qx - px) * (ys - py)) / dy;
    endfunction

    function longint floor_unit(longint v);
      if (v >= 0) return v / UNIT;
      return -((-v + UNIT - 1) / UNIT);
    endfunction

    function logic signed [tsg_pkg::RW-1:0] clamp12(longint v);
      if (v > 2047) return 12'sd2047;
      if (v < -2048) return -12'sd2048;
      return v[tsg_pkg::RW-1:0];
    endfunction

    // Sort the vertices and queue one expected span per row
    function void note_triangle(tsg_pkg::tri_in_t t);
      longint ax, ay, bx, by, cx, cy, tmp;
      longint y0, ylast, ymid, total, count, y, ys, xl, xr, first, final_col;
      tsg_pkg::span_out_t s;
      bit clip;
      ax = t.top_x; ay = t.top_y; bx = t.mid_x; by = t.mid_y;
      cx = t.far_x; cy = t.far_y;
      if (ay > by) begin tmp = ay; ay = by; by = tmp; tmp = ax; ax = bx; bx = tmp; end
      if (by > cy) begin tmp = by; by = cy; cy = tmp; tmp = bx; bx = cx; cx = tmp; end
      if (ay > by) begin tmp = ay; ay = by; by = tmp; tmp = ax; ax = bx; bx = tmp; end
      y0 = ay / UNIT;
      ylast = floor_unit(cy);
      ymid = floor_unit(by);
      total = (ylast >= y0) ? ylast - y0 + 1 : 0;
      clip = total > ROW_LIMIT;
      count = clip ? ROW_LIMIT : total;
      tris_noted++;
      for (longint k = 0; k < count; k++) begin
        y = y0 + k;
        ys = y * UNIT;
        if (y <= ymid) begin
          xl = edge_at(ax, ay, bx, by, ys, bx);
          xr = edge_at(ax, ay, cx, cy, ys, ax);
        end else begin
          xl = edge_at(bx, by, cx, cy, ys, bx);
          xr = edge_at(ax, ay, cx, cy, ys, cx);
        end
        if (xl > xr) begin tmp = xl; xl = xr; xr = tmp; end
        first = xl / UNIT;
        final_col = floor_unit(xr);
        s.row = y[tsg_pkg::RW-1:0];
        s.span_first = clamp12(first);
        s.span_final = clamp12(final_col);
        s.span_empty = first > final_col;
        s.clipped = clip;
        s.last_span = (k == count - 1);
        pending_spans.push_back(s);
      end
    endfunction

    // Compare one finished span with the oldest expectation
    function void check_span(tsg_pkg::span_out_t got);
      tsg_pkg::span_out_t want;
      spans_checked++;
      if (pending_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected span %p", got);
        return;
      end
      want = pending_spans.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("span mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tsg_pkg::tri_in_t in_data;
  logic out_valid;
  logic out_stall;
  tsg_pkg::span_out_t out_data;
  span_scoreboard sb;
  bit stall_quiet;
  int stall_run;

  triangle_span_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Check accepted spans and drive a random stall, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_span(out_data);
      if (stall_quiet) begin
        stall_run <= 0;
        out_stall <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run <= stall_run - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        stall_run <= $urandom_range(10, 60);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  // Hand one triangle over, then hold off for a random gap
  task automatic send_tri(tsg_pkg::tri_in_t t);
    int g;
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_triangle(t);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_verts(int ax, int ay, int bx, int by, int cx, int cy);
    tsg_pkg::tri_in_t t;
    t.top_x = ax; t.top_y = ay; t.mid_x = bx; t.mid_y = by;
    t.far_x = cx; t.far_y = cy;
    send_tri(t);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.pending_spans.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Random vertex near a base point; mostly short triangles, a few tall
  function automatic int near(int base, int spread);
    return base + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  initial begin
    int bx, by, spread;
    tsg_pkg::tri_in_t t;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    stall_quiet = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flat edges, no rows, tall clip, extremes, middle row
    send_verts(0, 0, 0, 0, 0, 0);
    send_verts(16, 0, 160, 160, 320, 320);
    send_verts(0, 0, 80, 1, 40, 160);
    send_verts(0, 0, 80, 2, 40, 160);
    send_verts(0, 0, 80, 3, 40, 160);
    send_verts(0, 0, 40, 158, 80, 160);
    send_verts(100, 160, 0, 0, 50, 80);
    send_verts(0, 8, 16, 4, 8, 15);
    send_verts(0, -20, 32, -8, -16, 30);
    send_verts(0, 0, 200, 2000, -200, 4000);
    send_verts(-32768, 0, 32767, 16, 0, 32);
    send_verts(32767, -32768, -32768, -32767, 0, -32000);
    send_verts(-32768, 32000, 32767, 32767, 0, 32760);
    send_verts(0, -5, 0, -3, 0, -1);
    send_verts(-32768, -32768, 32767, 32767, -1, 0);
    send_verts(16'h5555, 16'hAA00, 16'hAAAA, 16'hAB00, 16'h7FFF, 16'hABFF);
    send_verts(48, 33, 48, 33, -48, 64);
    send_verts(10, 47, 90, 48, 30, 49);

    // Pause until every span has come out
    in_valid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);

    for (int i = 0; i < RAND_TRIS; i++) begin
      stall_quiet = (i / 60) % 2 == 1 && (i % 60) < 15;
      if ($urandom_range(0, 19) == 0) begin
        t = {$urandom, $urandom, $urandom};
        send_tri(t);
      end else begin
        spread = ($urandom_range(0, 24) == 0) ? 800 : $urandom_range(4, 200);
        bx = near(0, 30000);
        by = near(0, 30000);
        send_verts(near(bx, spread), near(by, spread), near(bx, spread),
                   near(by, spread), near(bx, spread), near(by, spread));
      end
    end
    in_valid <= 1'b0;
    stall_quiet = 0;
    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d triangles, %0d spans compared", sb.tris_noted, sb.spans_checked);
    if (sb.mismatches == 0 && sb.pending_spans.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d spans missing", sb.mismatches, sb.pending_spans.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tsg_pkg.sv
hw/rtl/tsg_ctrl.sv
hw/rtl/tsg_dpath.sv
hw/rtl/triangle_span_generator.sv
dv/tb_top.sv
